// ===== rtl/wavetable_oscillator_cubic_unit_assert.svh =====
// ---------------------------------------------------------------------------
// Wavetable oscillator assertion macros
// Shorthand for clocked assertions that are disabled during reset.
// ---------------------------------------------------------------------------
`ifndef WAVETABLE_OSCILLATOR_CUBIC_UNIT_ASSERT_SVH
`define WAVETABLE_OSCILLATOR_CUBIC_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define WOCU_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define WOCU_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/wocu_pkg.sv =====
// ---------------------------------------------------------------------------
// Wavetable oscillator package
// Shared constants, register map and beat types of the oscillator.
// ---------------------------------------------------------------------------
package wocu_pkg;

    localparam int SAMPLE_WIDTH     = 16;
    localparam int TABLE_SIZE_DEF   = 1024;
    localparam int NUM_WAVES_DEF    = 5;
    localparam int PHASE_WIDTH_DEF  = 32;

    localparam int PADDR_W = 4;

    localparam logic [1:0] REG_PHASE_INC = 2'd0;
    localparam logic [1:0] REG_WAVE_SEL  = 2'd1;
    localparam logic [1:0] REG_VOLUME    = 2'd2;

    localparam logic [31:0] PHASE_INC_RST = 32'd39370533;
    localparam logic [2:0]  WAVE_SEL_RST  = 3'd0;
    localparam logic [15:0] VOLUME_RST    = 16'd32768;

    // Waveform selects from this value upward are silent.
    localparam logic [2:0]  WAVE_SILENT   = 3'd5;

    localparam logic ACT_TICK  = 1'b0;
    localparam logic ACT_WRITE = 1'b1;

    typedef struct packed {
        logic                           action;
        logic [2:0]                     write_bank;
        logic [9:0]                     write_index;
        logic signed [SAMPLE_WIDTH-1:0] write_value;
    } item_t;

    typedef struct packed {
        logic signed [SAMPLE_WIDTH-1:0] sample_out;
        logic                           saturated;
    } result_t;

endpackage

// ===== rtl/wocu_ram.sv =====
// ---------------------------------------------------------------------------
// Wavetable oscillator RAM
// Single-port synchronous RAM with a registered read.
// ---------------------------------------------------------------------------
module wocu_ram #(
    parameter int WIDTH = wocu_pkg::SAMPLE_WIDTH,
    parameter int DEPTH = wocu_pkg::TABLE_SIZE_DEF,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    addr,
    input  logic [WIDTH-1:0] wdata,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        else
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/wavetable_oscillator_cubic_unit.sv =====
// ---------------------------------------------------------------------------
// Wavetable oscillator with cubic interpolation
// Input beats either load one sample into a waveform bank or tick the
// oscillator, which advances the phase and returns one interpolated sample.
// The item channel carries one beat of type item_t; the sample channel
// returns one result_t beat per tick and nothing for a table write.
// A write beat completes on acceptance. A tick passes through READ (four
// reads of the single RAM port), COEF (the coefficients), three Horner
// steps of MUL and ADD, then VOL (the volume product), the multiplies all
// on one shared multiplier, and DONE, which registers the result. A silent
// tick goes straight to DONE. A new beat is accepted only once the result
// is registered, even while the previous result still waits in the output
// register. If the receiver stalls, the following tick holds in DONE until
// the output register frees up.
// Reset clears the phase and loads the register defaults; table contents
// are undefined until written. The APB port holds the phase increment at
// 0x0, the waveform select at 0x4 and the volume at 0x8. TABLE_SIZE must
// be a power of two.
// ---------------------------------------------------------------------------
`include "wavetable_oscillator_cubic_unit_assert.svh"

module wavetable_oscillator_cubic_unit #(
    parameter int TABLE_SIZE  = wocu_pkg::TABLE_SIZE_DEF,
    parameter int NUM_WAVES   = wocu_pkg::NUM_WAVES_DEF,
    parameter int PHASE_WIDTH = wocu_pkg::PHASE_WIDTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          item_valid,
    output logic                          item_ready,
    input  wocu_pkg::item_t               item,
    output logic                          sample_valid,
    input  logic                          sample_ready,
    output wocu_pkg::result_t             sample,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [wocu_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    localparam int SW     = wocu_pkg::SAMPLE_WIDTH;
    localparam int IDX_W  = $clog2(TABLE_SIZE);
    localparam int FPOS   = PHASE_WIDTH - IDX_W;
    localparam int BANK_W = (NUM_WAVES > 1) ? $clog2(NUM_WAVES) : 1;
    localparam int DEPTH  = NUM_WAVES * TABLE_SIZE;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int ACC_W  = SW + 8;
    localparam int MOP_W  = 17;
    localparam int PROD_W = ACC_W + MOP_W;

    localparam logic signed [PROD_W:0] RND16 = (PROD_W+1)'(32768);
    localparam logic signed [PROD_W:0] RND15 = (PROD_W+1)'(16384);
    localparam logic signed [PROD_W:0] SMAX  = (PROD_W+1)'((64'd1 << (SW - 1)) - 64'd1);
    localparam logic signed [PROD_W:0] SMIN  = -SMAX - (PROD_W+1)'(1);

    typedef enum logic [6:0] {
        ST_IDLE = 7'b0000001,
        ST_READ = 7'b0000010,
        ST_COEF = 7'b0000100,
        ST_MUL  = 7'b0001000,
        ST_ADD  = 7'b0010000,
        ST_VOL  = 7'b0100000,
        ST_DONE = 7'b1000000
    } state_t;

    state_t                    state_reg, state_next;
    logic [2:0]                rd_cnt_reg, rd_cnt_next;
    logic [1:0]                step_cnt_reg, step_cnt_next;
    logic                      silent_reg, silent_next;
    logic [15:0]               f_reg, f_next;
    logic signed [SW-1:0]      v0_reg, v0_next, v1_reg, v1_next;
    logic signed [SW-1:0]      v2_reg, v2_next, v3_reg, v3_next;
    logic signed [ACC_W-1:0]   q_reg, q_next, r_reg, r_next;
    logic signed [ACC_W-1:0]   acc_reg, acc_next;
    logic signed [PROD_W-1:0]  prod_reg, prod_next;
    logic [PHASE_WIDTH-1:0]    phase_reg, phase_next;
    logic [31:0]               inc_reg;
    logic [2:0]                sel_reg;
    logic [15:0]               vol_reg;
    logic                      out_valid_reg, out_valid_next;
    wocu_pkg::result_t         out_data_reg, out_data_next;

    logic                      item_acc;
    logic                      cfg_wr;
    logic                      sel_silent;
    logic [PHASE_WIDTH+31:0]   inc_ext;
    logic [PHASE_WIDTH+15:0]   phase_ext;
    logic [IDX_W-1:0]          idx_cur;
    logic [15:0]               frac;
    logic [IDX_W-1:0]          rd_idx;
    logic [IDX_W+9:0]          wi_ext;
    logic                      wr_ok;
    logic                      ram_we;
    logic [ADDR_W-1:0]         ram_addr;
    logic [SW-1:0]             ram_rdata;
    logic signed [ACC_W-1:0]   v0x, v1x, v2x, v3x;
    logic signed [ACC_W-1:0]   p_c, q_c, r_c;
    logic signed [MOP_W-1:0]   mul_b;
    logic signed [PROD_W-1:0]  prod_c;
    logic signed [PROD_W:0]    rnd16_sum, rnd16_q;
    logic signed [PROD_W:0]    z_sum, z_q;
    logic signed [ACC_W-1:0]   horner_rnd;
    logic signed [ACC_W-1:0]   addend;
    wocu_pkg::result_t         result_c;

    assign pready       = 1'b1;
    assign item_ready   = (state_reg == ST_IDLE);
    assign item_acc     = item_valid && item_ready;
    assign cfg_wr       = psel && penable && pwrite;
    assign sample_valid = out_valid_reg;
    assign sample       = out_data_reg;

    assign sel_silent = (int'(sel_reg) >= NUM_WAVES) || (sel_reg >= wocu_pkg::WAVE_SILENT);

    assign inc_ext   = {{PHASE_WIDTH{1'b0}}, inc_reg};
    assign phase_ext = {phase_reg, 16'b0};
    assign idx_cur   = phase_ext[PHASE_WIDTH+15 -: IDX_W];
    assign frac      = phase_ext[FPOS+15 -: 16];
    assign rd_idx    = idx_cur + IDX_W'(rd_cnt_reg) - IDX_W'(1);
    assign wi_ext    = {{IDX_W{1'b0}}, item.write_index};

    assign wr_ok  = (int'(item.write_bank) < NUM_WAVES) && (int'(item.write_index) < TABLE_SIZE);
    assign ram_we = item_acc && (item.action == wocu_pkg::ACT_WRITE) && wr_ok;

    always_comb
    begin
        if (state_reg == ST_IDLE)
        begin
            ram_addr = ADDR_W'({item.write_bank[BANK_W-1:0], wi_ext[IDX_W-1:0]});
        end
        else
        begin
            ram_addr = ADDR_W'({sel_reg[BANK_W-1:0], rd_idx});
        end
    end

    wocu_ram #(
        .WIDTH(SW),
        .DEPTH(DEPTH)
    ) u_ram (
        .clk  (clk),
        .we   (ram_we),
        .addr (ram_addr),
        .wdata(item.write_value),
        .rdata(ram_rdata)
    );

    assign v0x = ACC_W'(v0_reg);
    assign v1x = ACC_W'(v1_reg);
    assign v2x = ACC_W'(v2_reg);
    assign v3x = ACC_W'(v3_reg);
    assign p_c = (v3x - v2x) - (v0x - v1x);
    assign q_c = (v0x - v1x) - p_c;
    assign r_c = v2x - v0x;

    assign mul_b  = (state_reg == ST_VOL) ? $signed({1'b0, vol_reg}) : $signed({1'b0, f_reg});
    assign prod_c = acc_reg * mul_b;

    assign rnd16_sum  = (PROD_W+1)'(prod_reg) + RND16;
    assign rnd16_q    = rnd16_sum >>> 16;
    assign horner_rnd = $signed(rnd16_q[ACC_W-1:0]);
    assign z_sum      = (PROD_W+1)'(prod_reg) + RND15;
    assign z_q        = z_sum >>> 15;

    always_comb
    begin
        case (step_cnt_reg)
            2'd0:    addend = q_reg;
            2'd1:    addend = r_reg;
            default: addend = v1x;
        endcase
    end

    always_comb
    begin
        if (silent_reg)
        begin
            result_c.sample_out = '0;
            result_c.saturated  = 1'b0;
        end
        else if (z_q > SMAX)
        begin
            result_c.sample_out = SMAX[SW-1:0];
            result_c.saturated  = 1'b1;
        end
        else if (z_q < SMIN)
        begin
            result_c.sample_out = SMIN[SW-1:0];
            result_c.saturated  = 1'b1;
        end
        else
        begin
            result_c.sample_out = z_q[SW-1:0];
            result_c.saturated  = 1'b0;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        rd_cnt_next    = rd_cnt_reg;
        step_cnt_next  = step_cnt_reg;
        silent_next    = silent_reg;
        f_next         = f_reg;
        v0_next        = v0_reg;
        v1_next        = v1_reg;
        v2_next        = v2_reg;
        v3_next        = v3_reg;
        q_next         = q_reg;
        r_next         = r_reg;
        acc_next       = acc_reg;
        prod_next      = prod_reg;
        phase_next     = phase_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;

        if (out_valid_reg && sample_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (item_acc && (item.action == wocu_pkg::ACT_TICK))
                begin
                    phase_next = phase_reg + inc_ext[PHASE_WIDTH-1:0];
                    if (sel_silent)
                    begin
                        silent_next = 1'b1;
                        state_next  = ST_DONE;
                    end
                    else
                    begin
                        silent_next = 1'b0;
                        rd_cnt_next = 3'd0;
                        state_next  = ST_READ;
                    end
                end
            end
            ST_READ:
            begin
                if (rd_cnt_reg == 3'd0)
                begin
                    f_next = frac;
                end
                else
                begin
                    v0_next = v1_reg;
                    v1_next = v2_reg;
                    v2_next = v3_reg;
                    v3_next = $signed(ram_rdata);
                end
                rd_cnt_next = rd_cnt_reg + 3'd1;
                if (rd_cnt_reg == 3'd4)
                begin
                    state_next = ST_COEF;
                end
            end
            ST_COEF:
            begin
                q_next        = q_c;
                r_next        = r_c;
                acc_next      = p_c;
                step_cnt_next = 2'd0;
                state_next    = ST_MUL;
            end
            ST_MUL:
            begin
                prod_next  = prod_c;
                state_next = ST_ADD;
            end
            ST_ADD:
            begin
                acc_next = horner_rnd + addend;
                if (step_cnt_reg == 2'd2)
                begin
                    state_next = ST_VOL;
                end
                else
                begin
                    step_cnt_next = step_cnt_reg + 2'd1;
                    state_next    = ST_MUL;
                end
            end
            ST_VOL:
            begin
                prod_next  = prod_c;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || sample_ready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = result_c;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rd_cnt_reg    <= 3'd0;
            step_cnt_reg  <= 2'd0;
            silent_reg    <= 1'b0;
            phase_reg     <= '0;
            out_valid_reg <= 1'b0;
            inc_reg       <= wocu_pkg::PHASE_INC_RST;
            sel_reg       <= wocu_pkg::WAVE_SEL_RST;
            vol_reg       <= wocu_pkg::VOLUME_RST;
        end
        else
        begin
            state_reg     <= state_next;
            rd_cnt_reg    <= rd_cnt_next;
            step_cnt_reg  <= step_cnt_next;
            silent_reg    <= silent_next;
            phase_reg     <= phase_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr)
            begin
                case (paddr[3:2])
                    wocu_pkg::REG_PHASE_INC: inc_reg <= pwdata;
                    wocu_pkg::REG_WAVE_SEL:  sel_reg <= pwdata[2:0];
                    wocu_pkg::REG_VOLUME:    vol_reg <= pwdata[15:0];
                    default:                 ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        f_reg        <= f_next;
        v0_reg       <= v0_next;
        v1_reg       <= v1_next;
        v2_reg       <= v2_next;
        v3_reg       <= v3_next;
        q_reg        <= q_next;
        r_reg        <= r_next;
        acc_reg      <= acc_next;
        prod_reg     <= prod_next;
        out_data_reg <= out_data_next;
    end

    always_comb
    begin
        case (paddr[3:2])
            wocu_pkg::REG_PHASE_INC: prdata = inc_reg;
            wocu_pkg::REG_WAVE_SEL:  prdata = {29'b0, sel_reg};
            wocu_pkg::REG_VOLUME:    prdata = {16'b0, vol_reg};
            default:                 prdata = 32'b0;
        endcase
    end

    `WOCU_ASSERT_NOW(a_read_count, state_reg == ST_READ, rd_cnt_reg <= 3'd4,
        "read counter ran past the four table reads")
    `WOCU_ASSERT_NOW(a_volume_after_steps, state_reg == ST_VOL, step_cnt_reg == 2'd2,
        "volume product started before all three Horner steps")
    `WOCU_ASSERT_NEXT(a_tick_reads,
        item_acc && (item.action == wocu_pkg::ACT_TICK) && !sel_silent,
        state_reg == ST_READ, "audible tick did not start the table reads")
    `WOCU_ASSERT_NEXT(a_write_holds_phase, item_acc && (item.action == wocu_pkg::ACT_WRITE),
        $stable(phase_reg), "write beat moved the phase")
    `WOCU_ASSERT_NEXT(a_write_no_result,
        item_acc && (item.action == wocu_pkg::ACT_WRITE) && !sample_valid,
        !sample_valid, "write beat produced a result beat")

endmodule
